// ===== rtl/core/rslm_pkg.sv =====
`default_nettype none
package rslm_pkg;

  localparam int CORNER_PIXELS = 2;
  localparam int CORNER_COUNT  = 2 * CORNER_PIXELS;
  localparam int K_W           = (CORNER_COUNT > 1) ? $clog2(CORNER_COUNT) : 1;

  localparam int FRAC              = 14;
  localparam int SHORT_EDGE_PIXELS = 36;
  localparam int MIN_Y_MM          = 50;
  localparam int MM_PER_METRE      = 1000;
  localparam int BLUE_STEP_MM      = 300;

  localparam logic signed [15:0] QUARTER_PI_Q13       = 16'sd6434;
  localparam logic signed [16:0] THREE_QUARTER_PI_Q13 = 17'sd19302;
  localparam logic signed [16:0] HALF_PI_Q13          = 17'sd12868;
  localparam logic signed [16:0] PI_Q13               = 17'sd25736;

  localparam logic [1:0] CFG_STRIP_PIXELS  = 2'd0;
  localparam logic [1:0] CFG_SHORT_EDGE    = 2'd1;
  localparam logic [1:0] CFG_LONG_EDGE     = 2'd2;
  localparam logic [1:0] CFG_PIXELS_PER_M  = 2'd3;

  typedef struct packed {
    logic signed [15:0] ray_angle;
    logic [15:0]        distance_mm;
    logic [7:0]         strip_offset;
    logic               scan_start;
  } in_item_t;

  typedef struct packed {
    logic [7:0] led_index;
    logic [2:0] blue_level;
    logic       last_pixel;
  } out_item_t;

  typedef struct packed {
    logic           load;
    logic           front_take;
    logic           cordic_init;
    logic           cordic_step;
    logic           mul;
    logic           sq;
    logic           sqrt_init;
    logic           sqrt_step;
    logic           side_take;
    logic           div_init;
    logic           div_step;
    logic           side_pix;
    logic           emit;
    logic           last;
    logic [4:0]     cnt;
    logic [K_W-1:0] k;
  } cmd_t;

  typedef struct packed {
    logic front;
    logic short_side;
    logic y_ok;
    logic ax_gt_short;
    logic ax_lt_long;
    logic front_new;
    logic side_new;
    logic reserved;
    logic out_free;
  } sts_t;

  function automatic logic signed [19:0] atan_q16(input logic [3:0] i);
    logic signed [19:0] v;
    case (i)
      4'd0:    v = 20'sd51472;
      4'd1:    v = 20'sd30386;
      4'd2:    v = 20'sd16055;
      4'd3:    v = 20'sd8150;
      4'd4:    v = 20'sd4091;
      4'd5:    v = 20'sd2047;
      4'd6:    v = 20'sd1024;
      4'd7:    v = 20'sd512;
      4'd8:    v = 20'sd256;
      4'd9:    v = 20'sd128;
      4'd10:   v = 20'sd64;
      4'd11:   v = 20'sd32;
      4'd12:   v = 20'sd16;
      4'd13:   v = 20'sd8;
      4'd14:   v = 20'sd4;
      default: v = 20'sd2;
    endcase
    return v;
  endfunction

  // level counts the thresholds k*300mm (k = 0..4) that the distance does not exceed
  function automatic logic [2:0] blue_of(input logic [39:0] dq);
    logic [2:0]  lvl;
    logic [39:0] step;
    lvl  = 3'd0;
    step = 40'(BLUE_STEP_MM) << FRAC;
    for (int k = 0; k < 5; k++) begin
      if (dq <= 40'(k) * step) lvl = lvl + 3'd1;
    end
    return lvl;
  endfunction

  function automatic logic is_reserved(input logic signed [17:0] idx);
    int centre [5];
    logic hit;
    centre[0] = 0;
    centre[1] = -SHORT_EDGE_PIXELS;
    centre[2] = 55;
    centre[3] = 91;
    centre[4] = 146;
    hit = 1'b0;
    for (int k = 0; k < 5; k++) begin
      if (int'(idx) >= centre[k] - CORNER_PIXELS && int'(idx) < centre[k] + CORNER_PIXELS)
        hit = 1'b1;
    end
    return hit;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/rslm_datapath.sv =====
`default_nettype none
module rslm_datapath (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire rslm_pkg::in_item_t   in_data,
  input  wire logic                 out_stall,
  output logic                      out_valid,
  output rslm_pkg::out_item_t       out_data,
  input  wire logic                 cfg_we,
  input  wire logic [1:0]           cfg_index,
  input  wire logic [11:0]          cfg_data,
  input  wire rslm_pkg::cmd_t       cmd,
  output rslm_pkg::sts_t            sts
);

  localparam logic signed [37:0] MIN_YQ = 38'(rslm_pkg::MIN_Y_MM) <<< rslm_pkg::FRAC;
  localparam logic [24:0] DIV_RECIP =
    25'(((64'd1 << 34) + 64'(rslm_pkg::MM_PER_METRE) - 64'd1) /
        64'(rslm_pkg::MM_PER_METRE));
  localparam logic signed [10:0] CP11 = 11'(rslm_pkg::CORNER_PIXELS);
  localparam logic signed [10:0] SHORT_PIX11 = 11'(rslm_pkg::SHORT_EDGE_PIXELS);

  logic [7:0]  strip_r;
  logic [11:0] short_r;
  logic [11:0] long_r;
  logic [7:0]  ppm_r;

  logic signed [15:0] angle_r;
  logic [15:0]        dist_r;
  logic [7:0]         offset_r;
  logic [23:0]        front_min_r;
  logic [23:0]        side_min_r;

  logic signed [19:0] cx_r, cy_r, cz_r;
  logic               flip_r;
  logic signed [37:0] xq_r, yq_r;
  logic [63:0]        sqa_r, sqb_r, v_r, res_r, bit_r;
  logic [39:0]        rem_r;
  logic [15:0]        quo_r;
  logic               xneg_r;
  logic signed [10:0] centre_r;
  logic [7:0]         pix_r;
  logic [2:0]         lvl_r;
  logic               corner_r;
  logic               out_valid_r;
  rslm_pkg::out_item_t out_r;

  // sector and angle reduction
  logic               sec_front, sec_short;
  logic signed [16:0] a17, theta, theta_red;
  logic               flip_nxt;
  logic signed [19:0] z_init;

  assign sec_front = (angle_r >= -rslm_pkg::QUARTER_PI_Q13) &&
                     (angle_r <= rslm_pkg::QUARTER_PI_Q13);
  assign sec_short = angle_r < -rslm_pkg::QUARTER_PI_Q13;
  assign a17       = {angle_r[15], angle_r};

  always_comb begin
    theta = sec_short ? a17 + rslm_pkg::THREE_QUARTER_PI_Q13
                      : a17 - {rslm_pkg::QUARTER_PI_Q13[15], rslm_pkg::QUARTER_PI_Q13};
    flip_nxt  = 1'b0;
    theta_red = theta;
    if (theta > rslm_pkg::HALF_PI_Q13) begin
      theta_red = theta - rslm_pkg::PI_Q13;
      flip_nxt  = 1'b1;
    end else if (theta < -rslm_pkg::HALF_PI_Q13) begin
      theta_red = theta + rslm_pkg::PI_Q13;
      flip_nxt  = 1'b1;
    end
    z_init = $signed({{3{theta_red[16]}}, theta_red}) <<< 3;
  end

  // one rotation step
  logic [3:0]         ci;
  logic signed [19:0] xsh, ysh, cx_nxt, cy_nxt, cz_nxt;
  assign ci  = cmd.cnt[3:0];
  assign xsh = cx_r >>> ci;
  assign ysh = cy_r >>> ci;
  always_comb begin
    if (!cz_r[19]) begin
      cx_nxt = cx_r - ysh;
      cy_nxt = cy_r + xsh;
      cz_nxt = cz_r - rslm_pkg::atan_q16(ci);
    end else begin
      cx_nxt = cx_r + ysh;
      cy_nxt = cy_r - xsh;
      cz_nxt = cz_r + rslm_pkg::atan_q16(ci);
    end
  end

  // projection
  logic signed [19:0] cc, ss;
  logic signed [16:0] d17;
  logic signed [36:0] pc, ps;
  assign cc  = flip_r ? -cx_r : cx_r;
  assign ss  = flip_r ? -cy_r : cy_r;
  assign d17 = $signed({1'b0, dist_r});
  assign pc  = d17 * cc;
  assign ps  = d17 * ss;

  logic [37:0] ax, short_q, long_q, cxc;
  assign ax      = xq_r[37] ? 38'(-xq_r) : 38'(xq_r);
  assign short_q = {12'd0, short_r, 14'd0};
  assign long_q  = {12'd0, long_r, 14'd0};
  assign cxc     = ax - short_q;

  // root step
  logic [63:0] sq_t;
  assign sq_t = res_r + bit_r;

  logic [23:0] dmm;
  assign dmm = {6'd0, res_r[31:14]};

  // divide by 1000 mm in Q14: drop the fraction, then multiply by the reciprocal
  logic [48:0] qprod;
  assign qprod = 49'(rem_r[37:14]) * 49'(DIV_RECIP);

  // side pixel
  logic signed [17:0] q18, idx;
  assign q18 = $signed({2'b00, quo_r});
  assign idx = (xneg_r ? -q18 : q18) + $signed({10'd0, offset_r});

  // corner pixel for the emitted beat
  logic signed [10:0] side_centre, kx, e11;
  logic [7:0]         epix;
  always_comb begin
    side_centre = $signed({3'b000, offset_r}) - SHORT_PIX11;
    if (side_centre[10]) side_centre = side_centre + $signed({3'b000, strip_r});
  end
  assign kx   = $signed(11'(cmd.k));
  assign e11  = centre_r + kx - CP11;
  assign epix = e11[10] ? e11[7:0] + strip_r : e11[7:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strip_r     <= 8'd182;
      short_r     <= 12'd300;
      long_r      <= 12'd460;
      ppm_r       <= 8'd60;
      front_min_r <= '1;
      side_min_r  <= '1;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          rslm_pkg::CFG_STRIP_PIXELS: strip_r <= cfg_data[7:0];
          rslm_pkg::CFG_SHORT_EDGE:   short_r <= cfg_data;
          rslm_pkg::CFG_LONG_EDGE:    long_r  <= cfg_data;
          rslm_pkg::CFG_PIXELS_PER_M: ppm_r   <= cfg_data[7:0];
          default: ;
        endcase
      end
      if (cmd.load && in_data.scan_start) begin
        front_min_r <= '1;
        side_min_r  <= '1;
      end
      if (cmd.front_take) front_min_r <= {8'd0, dist_r};
      if (cmd.side_take)  side_min_r  <= dmm;
      if (cmd.emit) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      angle_r  <= in_data.ray_angle;
      dist_r   <= in_data.distance_mm;
      offset_r <= in_data.strip_offset;
    end
    if (cmd.cordic_init) begin
      cx_r   <= 20'sd9949;
      cy_r   <= 20'sd0;
      cz_r   <= z_init;
      flip_r <= flip_nxt;
    end
    if (cmd.cordic_step) begin
      cx_r <= cx_nxt;
      cy_r <= cy_nxt;
      cz_r <= cz_nxt;
    end
    if (cmd.mul) begin
      if (sec_short) begin
        yq_r <= 38'(ps);
        xq_r <= -38'(pc);
      end else begin
        yq_r <= 38'(pc);
        xq_r <= 38'(ps);
      end
    end
    if (cmd.sq) begin
      sqa_r <= 64'(cxc[31:0]) * 64'(cxc[31:0]);
      sqb_r <= 64'(yq_r[31:0]) * 64'(yq_r[31:0]);
    end
    if (cmd.sqrt_init) begin
      v_r   <= sqa_r + sqb_r;
      res_r <= 64'd0;
      bit_r <= 64'd1 << 62;
    end
    if (cmd.sqrt_step) begin
      if (v_r >= sq_t) begin
        v_r   <= v_r - sq_t;
        res_r <= (res_r >> 1) + bit_r;
      end else begin
        res_r <= res_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
    if (cmd.div_init) begin
      rem_r  <= 40'(ax[31:0]) * 40'(ppm_r);
      quo_r  <= 16'd0;
      xneg_r <= xq_r[37];
    end
    if (cmd.div_step) quo_r <= {1'b0, qprod[48:34]};
    if (cmd.front_take) begin
      centre_r <= $signed({3'b000, offset_r});
      lvl_r    <= rslm_pkg::blue_of({10'd0, dist_r, 14'd0});
      corner_r <= 1'b1;
    end
    if (cmd.side_take) begin
      centre_r <= side_centre;
      lvl_r    <= rslm_pkg::blue_of(40'(res_r[31:0]));
      corner_r <= 1'b1;
    end
    if (cmd.side_pix) begin
      pix_r    <= idx[17] ? idx[7:0] + strip_r : idx[7:0];
      lvl_r    <= rslm_pkg::blue_of(40'(yq_r[31:0]));
      corner_r <= 1'b0;
    end
    if (cmd.emit) begin
      out_r.led_index  <= corner_r ? epix : pix_r;
      out_r.blue_level <= lvl_r;
      out_r.last_pixel <= cmd.last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign sts.front       = sec_front;
  assign sts.short_side  = sec_short;
  assign sts.y_ok        = yq_r > MIN_YQ;
  assign sts.ax_gt_short = ax > short_q;
  assign sts.ax_lt_long  = ax < long_q;
  assign sts.front_new   = {8'd0, dist_r} < front_min_r;
  assign sts.side_new    = dmm < side_min_r;
  assign sts.reserved    = rslm_pkg::is_reserved(idx);
  assign sts.out_free    = !out_valid_r || !out_stall;

endmodule
`default_nettype wire

// ===== rtl/core/rslm_ctrl.sv =====
`default_nettype none
module rslm_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire rslm_pkg::sts_t  sts,
  output rslm_pkg::cmd_t       cmd
);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_DECODE = 4'd1;
  localparam logic [3:0] ST_CORDIC = 4'd2;
  localparam logic [3:0] ST_MUL    = 4'd3;
  localparam logic [3:0] ST_CHECK  = 4'd4;
  localparam logic [3:0] ST_SQ     = 4'd5;
  localparam logic [3:0] ST_SUM    = 4'd6;
  localparam logic [3:0] ST_SQRT   = 4'd7;
  localparam logic [3:0] ST_CORNER = 4'd8;
  localparam logic [3:0] ST_DIVI   = 4'd9;
  localparam logic [3:0] ST_DIV    = 4'd10;
  localparam logic [3:0] ST_SIDE   = 4'd11;
  localparam logic [3:0] ST_EMIT   = 4'd12;

  localparam logic [4:0] CORDIC_LAST = 5'd15;
  localparam logic [4:0] SQRT_LAST   = 5'd31;
  localparam logic [4:0] DIV_LAST    = 5'd0;
  localparam logic [rslm_pkg::K_W-1:0] K_LAST = rslm_pkg::K_W'(rslm_pkg::CORNER_COUNT - 1);

  logic [3:0]              state_r, state_nxt;
  logic [4:0]              cnt_r, cnt_nxt;
  logic [rslm_pkg::K_W-1:0] k_r, k_nxt;
  logic                    single_r, single_nxt;

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    k_nxt      = k_r;
    single_nxt = single_r;
    cmd        = '0;
    cmd.cnt    = cnt_r;
    cmd.k      = k_r;
    cmd.last   = single_r || (k_r == K_LAST);
    in_stall   = state_r != ST_IDLE;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (sts.front) begin
          if (sts.front_new) begin
            cmd.front_take = 1'b1;
            single_nxt     = 1'b0;
            k_nxt          = '0;
            state_nxt      = ST_EMIT;
          end else begin
            state_nxt = ST_IDLE;
          end
        end else begin
          cmd.cordic_init = 1'b1;
          cnt_nxt         = 5'd0;
          state_nxt       = ST_CORDIC;
        end
      end
      ST_CORDIC: begin
        cmd.cordic_step = 1'b1;
        cnt_nxt         = cnt_r + 5'd1;
        if (cnt_r == CORDIC_LAST) state_nxt = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        if (!sts.y_ok) state_nxt = ST_IDLE;
        else if (sts.short_side) state_nxt = sts.ax_gt_short ? ST_SQ : ST_DIVI;
        else state_nxt = sts.ax_lt_long ? ST_DIVI : ST_IDLE;
      end
      ST_SQ: begin
        cmd.sq    = 1'b1;
        state_nxt = ST_SUM;
      end
      ST_SUM: begin
        cmd.sqrt_init = 1'b1;
        cnt_nxt       = 5'd0;
        state_nxt     = ST_SQRT;
      end
      ST_SQRT: begin
        cmd.sqrt_step = 1'b1;
        cnt_nxt       = cnt_r + 5'd1;
        if (cnt_r == SQRT_LAST) state_nxt = ST_CORNER;
      end
      ST_CORNER: begin
        if (sts.side_new) begin
          cmd.side_take = 1'b1;
          single_nxt    = 1'b0;
          k_nxt         = '0;
          state_nxt     = ST_EMIT;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_DIVI: begin
        cmd.div_init = 1'b1;
        cnt_nxt      = 5'd0;
        state_nxt    = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 5'd1;
        if (cnt_r == DIV_LAST) state_nxt = ST_SIDE;
      end
      ST_SIDE: begin
        if (!sts.reserved) begin
          cmd.side_pix = 1'b1;
          single_nxt   = 1'b1;
          k_nxt        = '0;
          state_nxt    = ST_EMIT;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_EMIT: begin
        // hold the beat until the output register frees up
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (cmd.last) state_nxt = ST_IDLE;
          else k_nxt = k_r + 1'b1;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      cnt_r    <= 5'd0;
      k_r      <= '0;
      single_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      k_r      <= k_nxt;
      single_r <= single_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/range_scan_to_led_strip_mapper_core.sv =====
// Range-scan ray to LED strip pixel mapper.
// Input channel (in_valid / in_stall / in_data): one scanner ray per beat.
// Output channel (out_valid / out_stall / out_data): pixel beats, last_pixel
// set on the final beat of a ray; a ray may give no beat at all.
// Configuration (cfg_we / cfg_index / cfg_data): write only while idle.
// One ray is handled at a time; in_stall is high from acceptance until the
// last pixel of that ray has been loaded into the output register.
// Steps per ray after acceptance, in the order the sequencer runs them:
//   front sector: decode, then one emit step per emitted pixel
//   side pixel:   16 CORDIC steps, multiply, check, scale to pixels, emit
//   far corner:   16 CORDIC steps, multiply, check, square, 32 root steps, emit
// A stalled receiver holds the output register; the sequencer waits in its
// emit step until the beat is taken, so no pixel is lost.
// Reset (rst_n low, synchronous) restores the default registers, sets both
// running minima to all ones and empties the output register.
`default_nettype none
module range_scan_to_led_strip_mapper_core (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire rslm_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output rslm_pkg::out_item_t      out_data,
  input  wire logic                cfg_we,
  input  wire logic [1:0]          cfg_index,
  input  wire logic [11:0]         cfg_data
);

  rslm_pkg::cmd_t cmd;
  rslm_pkg::sts_t sts;

  rslm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  rslm_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule
`default_nettype wire

// ===== tb/range_scan_to_led_strip_mapper_core_tb.sv =====
`timescale 1ns / 1ps
module range_scan_to_led_strip_mapper_core_tb;

  localparam int QPI = 6434;
  localparam int TQPI = 19302;
  localparam int HPI = 12868;
  localparam int PI = 25736;
  localparam int CORNER_PX = 2;
  localparam logic [23:0] MIN_ALL_ONES = 24'hFFFFFF;

  class pixel_scoreboard;
    logic [7:0]  strip_px;
    logic [11:0] short_mm;
    logic [11:0] long_mm;
    logic [7:0]  px_per_m;
    logic [23:0] front_min;
    logic [23:0] side_min;
    rslm_pkg::out_item_t pending[$];
    int          errors;
    int          checked;

    function void init();
      strip_px = 8'd182;
      short_mm = 12'd300;
      long_mm = 12'd460;
      px_per_m = 8'd60;
      front_min = MIN_ALL_ONES;
      side_min = MIN_ALL_ONES;
      errors = 0;
      checked = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [11:0] val);
      case (idx)
        rslm_pkg::CFG_STRIP_PIXELS: strip_px = val[7:0];
        rslm_pkg::CFG_SHORT_EDGE:   short_mm = val;
        rslm_pkg::CFG_LONG_EDGE:    long_mm = val;
        default:                    px_per_m = val[7:0];
      endcase
    endfunction

    function longint floor_shift(longint v, int s);
      if (v >= 0) return v >>> s;
      return -(((-v) - 1) >>> s) - 1;
    endfunction

    function void rotate(int theta, output longint c, output longint s);
      bit flip;
      longint x, y, z, nx;
      flip = 0;
      x = 9949;
      y = 0;
      if (theta > HPI) begin
        theta -= PI;
        flip = 1;
      end else if (theta < -HPI) begin
        theta += PI;
        flip = 1;
      end
      z = longint'(theta) * 8;
      for (int i = 0; i < 16; i++) begin
        if (z >= 0) begin
          nx = x - floor_shift(y, i);
          y = y + floor_shift(x, i);
          z -= rslm_pkg::atan_q16(i[3:0]);
        end else begin
          nx = x + floor_shift(y, i);
          y = y - floor_shift(x, i);
          z += rslm_pkg::atan_q16(i[3:0]);
        end
        x = nx;
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
    endfunction

    function longint root_floor(longint v);
      longint res, b;
      res = 0;
      b = 64'sd1 <<< 62;
      while (b > v) b = b >>> 2;
      while (b != 0) begin
        if (v >= res + b) begin
          v -= res + b;
          res = (res >>> 1) + b;
        end else res = res >>> 1;
        b = b >>> 2;
      end
      return res;
    endfunction

    function logic [2:0] level_of(longint dq);
      longint full;
      full = longint'(1500) <<< 14;
      if (dq >= full) return 3'd0;
      return 3'((full - dq) / (longint'(300) <<< 14));
    endfunction

    function void add_pixel(int idx, logic [2:0] lvl);
      rslm_pkg::out_item_t p;
      p.led_index = idx[7:0];
      p.blue_level = lvl;
      p.last_pixel = 1'b0;
      pending.push_back(p);
    endfunction

    function void add_corner(int centre, logic [2:0] lvl);
      int idx;
      for (int i = -CORNER_PX; i < CORNER_PX; i++) begin
        idx = centre + i;
        if (idx < 0) idx += int'(strip_px);
        add_pixel(idx, lvl);
      end
    endfunction

    function bit reserved_px(int idx);
      int centres[5];
      centres = '{0, -36, 55, 91, 146};
      foreach (centres[k])
        if (idx >= centres[k] - CORNER_PX && idx < centres[k] + CORNER_PX) return 1;
      return 0;
    endfunction

    function int add_side(longint xq, longint yq, int offset);
      int idx;
      idx = int'((xq * longint'(px_per_m)) / (longint'(1000) <<< 14)) + offset;
      if (reserved_px(idx)) return 0;
      if (idx < 0) idx += int'(strip_px);
      add_pixel(idx, level_of(yq));
      return 1;
    endfunction

    // predict the pixels of one accepted ray
    function void note_ray(rslm_pkg::in_item_t r);
      int angle, offset, n, centre;
      longint ray_mm, c, s, xq, yq, ax, cx, dq, dmm;
      angle = int'(r.ray_angle);
      ray_mm = longint'(r.distance_mm);
      offset = int'(r.strip_offset);
      n = 0;
      if (r.scan_start) begin
        front_min = MIN_ALL_ONES;
        side_min = MIN_ALL_ONES;
      end
      if (angle >= -QPI && angle <= QPI) begin
        if (ray_mm < longint'(front_min)) begin
          front_min = 24'(ray_mm);
          add_corner(offset, level_of(ray_mm <<< 14));
          n = 4;
        end
      end else if (angle < -QPI) begin
        rotate(angle + TQPI, c, s);
        yq = ray_mm * s;
        xq = -(ray_mm * c);
        if (yq > (longint'(50) <<< 14)) begin
          ax = xq < 0 ? -xq : xq;
          if (ax > (longint'(short_mm) <<< 14)) begin
            cx = ax - (longint'(short_mm) <<< 14);
            dq = root_floor(cx * cx + yq * yq);
            dmm = dq >>> 14;
            if (dmm < longint'(side_min)) begin
              side_min = 24'(dmm);
              centre = offset - 36;
              if (centre < 0) centre += int'(strip_px);
              add_corner(centre, level_of(dq));
              n = 4;
            end
          end else n = add_side(xq, yq, offset);
        end
      end else begin
        rotate(angle - QPI, c, s);
        yq = ray_mm * c;
        xq = ray_mm * s;
        ax = xq < 0 ? -xq : xq;
        if (yq > (longint'(50) <<< 14) && ax < (longint'(long_mm) <<< 14))
          n = add_side(xq, yq, offset);
      end
      if (n > 0) pending[$].last_pixel = 1'b1;
    endfunction

    function void check_pixel(rslm_pkg::out_item_t got);
      rslm_pkg::out_item_t want;
      checked++;
      if (pending.size() == 0) begin
        $display("%0t: unexpected pixel beat, expected none, got %p", $time, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.led_index !== want.led_index) begin
        $display("%0t: led_index expected %0d got %0d", $time,
                 want.led_index, got.led_index);
        errors++;
      end
      if (got.blue_level !== want.blue_level) begin
        $display("%0t: blue_level expected %0d got %0d", $time,
                 want.blue_level, got.blue_level);
        errors++;
      end
      if (got.last_pixel !== want.last_pixel) begin
        $display("%0t: last_pixel expected %0b got %0b", $time,
                 want.last_pixel, got.last_pixel);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_valid = 0;
  logic        in_stall;
  rslm_pkg::in_item_t  in_data = '0;
  logic        out_valid;
  logic        out_stall = 0;
  rslm_pkg::out_item_t out_data;
  logic        cfg_we = 0;
  logic [1:0]  cfg_index = '0;
  logic [11:0] cfg_data = '0;

  pixel_scoreboard sb;
  bit calm;
  int rays_sent;

  range_scan_to_led_strip_mapper_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  initial begin
    #20000000;
    $display("TEST FAILED");
    $finish;
  end

  // receiver: check every accepted beat, stall at random
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) sb.check_pixel(out_data);
      out_stall <= calm ? 1'b0 : ($urandom_range(99) < 13);
    end
  end

  // valid stays high after acceptance until the next beat or an idle cycle
  task automatic send_ray(rslm_pkg::in_item_t r);
    while (!calm && $urandom_range(99) < 13) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_ray(r);
    rays_sent++;
  endtask

  task automatic ray(int angle, int mm, int offset, bit start);
    rslm_pkg::in_item_t r;
    r.ray_angle = 16'(angle);
    r.distance_mm = 16'(mm);
    r.strip_offset = 8'(offset);
    r.scan_start = start;
    send_ray(r);
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    while (sb.pending.size() != 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
    repeat (80) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [11:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(idx, val);
    @(posedge clk);
  endtask

  task automatic random_ray();
    int kind;
    kind = $urandom_range(9);
    if (kind < 3)
      ray($urandom_range(2 * QPI) - QPI, $urandom_range(3000), $urandom_range(255),
          $urandom_range(3) == 0);
    else if (kind < 6)
      ray(-$urandom_range(PI, QPI + 1), $urandom_range(2500), $urandom_range(255),
          $urandom_range(4) == 0);
    else if (kind < 9)
      ray($urandom_range(PI, QPI + 1), $urandom_range(2500), $urandom_range(255),
          $urandom_range(4) == 0);
    else
      ray($urandom_range(2 * PI) - PI, $urandom_range(65535), $urandom_range(255),
          $urandom_range(1));
  endtask

  initial begin
    sb = new();
    sb.init();
    calm = 0;
    rays_sent = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: front minima, corner wrap, side pixels, reserved, extremes
    ray(0, 100, 91, 1);
    ray(QPI, 50, 0, 0);
    ray(-QPI, 60, 1, 0);
    ray(100, 0, 255, 0);
    ray(0, 65535, 10, 1);
    ray(-PI, 400, 91, 1);
    ray(-TQPI, 1000, 91, 0);
    ray(-TQPI + 3000, 800, 0, 0);
    ray(-QPI - 1, 2000, 20, 0);
    ray(-TQPI - 2000, 300, 100, 1);
    ray(HPI, 200, 91, 0);
    ray(PI, 300, 0, 0);
    ray(QPI + 1, 65535, 255, 0);
    ray(HPI + 2000, 400, 57, 0);
    ray(-25736, 65535, 255, 1);
    ray(-1, 1, 128, 1);
    drain();

    write_reg(rslm_pkg::CFG_STRIP_PIXELS, 12'd1);
    write_reg(rslm_pkg::CFG_SHORT_EDGE, 12'd0);
    write_reg(rslm_pkg::CFG_LONG_EDGE, 12'd4095);
    write_reg(rslm_pkg::CFG_PIXELS_PER_M, 12'd255);
    ray(0, 10, 0, 1);
    ray(-TQPI, 500, 3, 0);
    ray(HPI, 900, 5, 0);
    ray(-HPI - 3000, 1500, 40, 1);
    for (int i = 0; i < 30; i++) random_ray();
    drain();

    write_reg(rslm_pkg::CFG_STRIP_PIXELS, 12'd255);
    write_reg(rslm_pkg::CFG_SHORT_EDGE, 12'd4095);
    write_reg(rslm_pkg::CFG_LONG_EDGE, 12'd0);
    write_reg(rslm_pkg::CFG_PIXELS_PER_M, 12'd1);
    calm = 1;
    for (int i = 0; i < 30; i++) random_ray();
    calm = 0;
    drain();

    write_reg(rslm_pkg::CFG_STRIP_PIXELS, 12'd0);
    write_reg(rslm_pkg::CFG_SHORT_EDGE, 12'd300);
    write_reg(rslm_pkg::CFG_LONG_EDGE, 12'd460);
    write_reg(rslm_pkg::CFG_PIXELS_PER_M, 12'd60);
    for (int i = 0; i < 50; i++) random_ray();
    drain();

    $display("Covered %0d rays and %0d pixel beats over four register settings.",
             rays_sent, sb.checked);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
